>>> rtl/core/mtc_pkg.sv
// ----------------------------------------------------------------------------
// Morse table codec package
// Shared opcodes, character constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    SEL_ROW    = 2'd0,
    SEL_SLASHQ = 2'd1,
    SEL_SPACE  = 2'd2,
    SEL_HIT    = 2'd3
  } sel_t;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic cnt_clr;
    logic rd_srch;
    logic hit_save;
    logic pos_inc;
    logic tok_clr;
    logic emit;
    logic emit_last;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic in_enc;
    logic in_dec;
    logic in_dec_ends;
    logic clr_done;
    logic slot_free;
    logic enc_has;
    logic pos_zero;
    logic tok_empty;
    logic tok_slash;
    logic match;
    logic srch_done;
  } sts_t;

endpackage

>>> rtl/core/mtc_ctrl.sv
// ----------------------------------------------------------------------------
// Morse table codec controller
// Sequences the clearing pass, encode output and decode table search.
// ----------------------------------------------------------------------------
module mtc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mtc_pkg::sts_t sts,
  output mtc_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_ENC    = 7'b0000100,
    S_ENC_SP = 7'b0001000,
    S_DEC    = 7'b0010000,
    S_SRCH   = 7'b0100000,
    S_HIT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = mtc_pkg::SEL_ROW;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.in_enc) begin
            state_nxt = S_ENC;
          end else if (sts.in_dec && sts.in_dec_ends) begin
            state_nxt = S_DEC;
          end
        end
      end
      S_ENC: begin
        if (sts.slot_free) begin
          if (sts.enc_has) begin
            cmd.emit    = 1'b1;
            cmd.sel     = mtc_pkg::SEL_ROW;
            cmd.pos_inc = 1'b1;
          end else begin
            cmd.emit  = sts.pos_zero;
            cmd.sel   = mtc_pkg::SEL_SLASHQ;
            state_nxt = S_ENC_SP;
          end
        end
      end
      S_ENC_SP: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.sel       = mtc_pkg::SEL_SPACE;
          state_nxt     = S_IDLE;
        end
      end
      S_DEC: begin
        if (sts.tok_empty) begin
          cmd.tok_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else if (sts.tok_slash) begin
          if (sts.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.sel       = mtc_pkg::SEL_SPACE;
            cmd.tok_clr   = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.match) begin
          cmd.hit_save = 1'b1;
          state_nxt    = S_HIT;
        end else if (sts.srch_done) begin
          cmd.tok_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_srch = 1'b1;
        end
      end
      S_HIT: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.sel       = mtc_pkg::SEL_HIT;
          cmd.tok_clr   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/core/mtc_dp.sv
// ----------------------------------------------------------------------------
// Morse table codec datapath
// Code table memory, token buffer, counters and the output register.
// ----------------------------------------------------------------------------
module mtc_dp #(
  parameter int TABLE_ENTRIES = 256,
  parameter int CODE_CHARS    = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    in_opcode,
  input  logic [7:0]    in_entry_index,
  input  logic [3:0]    in_char_pos,
  input  logic [7:0]    in_byte_value,
  input  logic          in_end_of_text,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last,
  input  mtc_pkg::cmd_t cmd,
  output mtc_pkg::sts_t sts
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int LEN_W = $clog2(CODE_CHARS + 1);
  localparam int ROW_W = CODE_CHARS * 8;

  logic [ROW_W-1:0] mem [TABLE_ENTRIES];
  logic [ROW_W-1:0] rd_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_vld_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] hit_r;
  logic [7:0]       u_r;
  logic             enc_ok_r;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [ROW_W-1:0] tok_r, tok_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic [7:0]       u_in;
  logic             u_in_ok;
  logic             is_ws;
  logic             cnt_in_range;
  logic             load_we;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       row_byte;
  logic             row_match;
  logic [7:0]       emit_char;

  assign u_in = ((in_byte_value >= mtc_pkg::CH_LC_A) && (in_byte_value <= mtc_pkg::CH_LC_Z))
                ? (in_byte_value - mtc_pkg::CASE_OFS) : in_byte_value;
  assign u_in_ok = ({1'b0, u_in} < 9'(TABLE_ENTRIES));
  assign is_ws = (in_byte_value == mtc_pkg::CH_SPACE) ||
                 ((in_byte_value >= mtc_pkg::CH_TAB) && (in_byte_value <= mtc_pkg::CH_CR));
  assign cnt_in_range = (cnt_r < CNT_W'(TABLE_ENTRIES));

  assign load_we = cmd.capture && (in_opcode == mtc_pkg::OP_LOAD) &&
                   ({1'b0, in_entry_index} < 9'(TABLE_ENTRIES)) &&
                   ({1'b0, in_char_pos} < 5'(CODE_CHARS));
  assign rd_en   = (cmd.rd_srch && cnt_in_range) ||
                   (cmd.capture && (in_opcode == mtc_pkg::OP_ENCODE) && u_in_ok);
  assign rd_addr = cmd.rd_srch ? cnt_r[IDX_W-1:0] : u_in[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[cnt_r[IDX_W-1:0]] <= '0;
    end else if (load_we) begin
      for (int i = 0; i < CODE_CHARS; i++) begin
        if (in_char_pos == 4'(i)) begin
          mem[in_entry_index[IDX_W-1:0]][i*8 +: 8] <= in_byte_value;
        end
      end
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_comb begin
    row_byte = '0;
    for (int i = 0; i < CODE_CHARS; i++) begin
      if (pos_r == LEN_W'(i)) begin
        row_byte = rd_r[i*8 +: 8];
      end
    end
  end

  always_comb begin
    row_match = 1'b1;
    for (int i = 0; i < CODE_CHARS; i++) begin
      if (LEN_W'(i) < len_r) begin
        if ((rd_r[i*8 +: 8] != tok_r[i*8 +: 8]) || (rd_r[i*8 +: 8] == 8'h00)) begin
          row_match = 1'b0;
        end
      end else if (LEN_W'(i) == len_r) begin
        if (rd_r[i*8 +: 8] != 8'h00) begin
          row_match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.clr_wr || (cmd.rd_srch && cnt_in_range)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.capture) begin
      pos_nxt = '0;
    end else if (cmd.pos_inc) begin
      pos_nxt = pos_r + LEN_W'(1);
    end
  end

  always_comb begin
    tok_nxt = tok_r;
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (cmd.tok_clr) begin
      tok_nxt = '0;
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.capture && (in_opcode == mtc_pkg::OP_DECODE) && !is_ws) begin
      if (len_r < LEN_W'(CODE_CHARS)) begin
        for (int i = 0; i < CODE_CHARS; i++) begin
          if (len_r == LEN_W'(i)) begin
            tok_nxt[i*8 +: 8] = in_byte_value;
          end
        end
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      mtc_pkg::SEL_ROW:    emit_char = row_byte;
      mtc_pkg::SEL_SLASHQ: emit_char = (u_r == mtc_pkg::CH_SPACE) ? mtc_pkg::CH_SLASH
                                                                   : mtc_pkg::CH_QUEST;
      mtc_pkg::SEL_SPACE:  emit_char = mtc_pkg::CH_SPACE;
      mtc_pkg::SEL_HIT:    emit_char = 8'(hit_r);
      default:             emit_char = mtc_pkg::CH_SPACE;
    endcase
  end

  assign sts.slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pos_r       <= '0;
      tok_r       <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      tok_r       <= tok_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      rd_vld_r    <= cmd.rd_srch && cnt_in_range;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IDX_W-1:0];
    if (cmd.capture) begin
      u_r      <= u_in;
      enc_ok_r <= u_in_ok;
    end
    if (cmd.hit_save) begin
      hit_r <= rd_idx_r;
    end
    if (cmd.emit) begin
      out_char_r <= emit_char;
      out_last_r <= cmd.emit_last;
    end
  end

  assign sts.in_enc      = (in_opcode == mtc_pkg::OP_ENCODE);
  assign sts.in_dec      = (in_opcode == mtc_pkg::OP_DECODE);
  assign sts.in_dec_ends = is_ws || in_end_of_text;
  assign sts.clr_done    = (cnt_r == CNT_W'(TABLE_ENTRIES - 1));
  assign sts.enc_has     = enc_ok_r && (pos_r < LEN_W'(CODE_CHARS)) && (row_byte != 8'h00);
  assign sts.pos_zero    = (pos_r == '0);
  assign sts.tok_empty   = ovf_r || (len_r == '0);
  assign sts.tok_slash   = (len_r == LEN_W'(1)) && (tok_r[7:0] == mtc_pkg::CH_SLASH);
  assign sts.match       = rd_vld_r && row_match;
  assign sts.srch_done   = rd_vld_r && (rd_idx_r == IDX_W'(TABLE_ENTRIES - 1));

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

>>> rtl/core/morse_table_codec_core.sv
// Load: written at transfer, in_ready stays high. Encode: n+1 results, 2 if n is 0.
// Decode: a token is resolved by a table search that reads one row per cycle.
// Throughput: one item at a time, the next transfer once the current item is finished.
// Reset: synchronous active-low rst_n, then a clearing pass over all TABLE_ENTRIES rows
// zeroes the code table before the first input transfer.
// ----------------------------------------------------------------------------
// Morse table codec core
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module morse_table_codec_core #(
  parameter int TABLE_ENTRIES = 256,
  parameter int CODE_CHARS    = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_entry_index,
  input  logic [3:0] in_char_pos,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  mtc_pkg::cmd_t cmd;
  mtc_pkg::sts_t sts;

  mtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CODE_CHARS    (CODE_CHARS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_char_pos    (in_char_pos),
    .in_byte_value  (in_byte_value),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

>>> rtl/core/mtc_checker.sv
// ----------------------------------------------------------------------------
// Morse table codec checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module mtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during the table clearing pass");

  a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == mtc_pkg::OP_LOAD)) |=> in_ready)
    else $error("load transfer left the core busy");

  a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == mtc_pkg::OP_ENCODE)) |=> !in_ready)
    else $error("encode transfer did not occupy the core");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind morse_table_codec_core mtc_checker u_mtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_opcode (in_opcode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .out_last  (out_last)
);
